/* rtl/meac_pkg.sv */
// Package: shared types, constants and helpers of the membrane atom classifier.
package meac_pkg;
	localparam int COORD_BITS = 24;
	localparam int LIPID_DEPTH = 1024;
	localparam int ADDR_BITS = $clog2(LIPID_DEPTH);
	localparam int FILL_BITS = $clog2(LIPID_DEPTH + 1);
	localparam int TOTAL_BITS = 24;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
	localparam int DELTA_BITS = COORD_BITS + 2;
	localparam int MAG_BITS = 25;
	localparam logic [MAG_BITS-1:0] DELTA_CLAMP = 25'h100_0000;
	localparam int SQ_BITS = 2 * MAG_BITS;
	localparam int SUM_BITS = SQ_BITS + 1;
	localparam int BOX_BITS = 23;
	localparam int RAD_BITS = 46;

	localparam logic [1:0] KIND_TOP = 2'd0;
	localparam logic [1:0] KIND_BOTTOM = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic [1:0] LEAF_NONE = 2'd0;
	localparam logic [1:0] LEAF_TOP = 2'd1;
	localparam logic [1:0] LEAF_BOTTOM = 2'd2;

	localparam logic [2:0] REG_AXIS_A = 3'd0;
	localparam logic [2:0] REG_AXIS_B = 3'd1;
	localparam logic [2:0] REG_NORMAL = 3'd2;
	localparam logic [2:0] REG_BOX_A = 3'd3;
	localparam logic [2:0] REG_BOX_B = 3'd4;
	localparam logic [2:0] REG_RADIUS = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic signed [COORD_BITS-1:0] coord_0;
		logic signed [COORD_BITS-1:0] coord_1;
		logic signed [COORD_BITS-1:0] coord_2;
		logic [23:0] atom_id;
	} in_item_t;

	typedef struct packed {
		logic [23:0] atom_out;
		logic [1:0] leaflet;
		logic [TOTAL_BITS-1:0] top_total;
		logic [TOTAL_BITS-1:0] bottom_total;
	} out_item_t;

	typedef struct packed {
		logic [1:0] axis_a;
		logic [1:0] axis_b;
		logic [1:0] normal;
		logic [BOX_BITS-1:0] box_a;
		logic [BOX_BITS-1:0] box_b;
		logic [RAD_BITS-1:0] radius_sq;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a;
		logic signed [COORD_BITS-1:0] b;
		logic signed [COORD_BITS-1:0] n;
	} proj_t;

	// Verdict of one lipid against the query atom.
	typedef struct packed {
		logic valid;
		logic near;
		logic same;
		logic above;
	} test_t;

	function automatic logic signed [COORD_BITS-1:0] pick(
		input logic [1:0] sel,
		input logic signed [COORD_BITS-1:0] c0,
		input logic signed [COORD_BITS-1:0] c1,
		input logic signed [COORD_BITS-1:0] c2);
		case (sel)
			2'd1: pick = c1;
			2'd2: pick = c2;
			default: pick = c0;
		endcase
	endfunction
endpackage

/* rtl/meac_store.sv */
// Lipid position memory with registered read port.
module meac_store (
	input logic clk,
	input logic we,
	input logic [meac_pkg::ADDR_BITS-1:0] waddr,
	input meac_pkg::proj_t wdata,
	input logic [meac_pkg::ADDR_BITS-1:0] raddr,
	output meac_pkg::proj_t rdata
);
	meac_pkg::proj_t mem [meac_pkg::LIPID_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

/* rtl/meac_dist.sv */
// Shared distance and height unit: two pipeline stages per lipid.
module meac_dist (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input meac_pkg::proj_t atom,
	input meac_pkg::proj_t lipid,
	input meac_pkg::cfg_t cfg,
	output meac_pkg::test_t result
);
	logic [meac_pkg::MAG_BITS-1:0] mag_a_s1, mag_b_s1;
	logic same_s1, above_s1, valid_s1;
	logic [meac_pkg::SQ_BITS-1:0] sq_a_s2, sq_b_s2;
	logic same_s2, above_s2, valid_s2;

	function automatic logic [meac_pkg::MAG_BITS-1:0] wrap_mag(
		input logic signed [meac_pkg::COORD_BITS-1:0] x,
		input logic signed [meac_pkg::COORD_BITS-1:0] y,
		input logic [meac_pkg::BOX_BITS-1:0] box);
		logic signed [meac_pkg::DELTA_BITS-1:0] d, bx, twod;
		logic [meac_pkg::DELTA_BITS-1:0] m;
		d = meac_pkg::DELTA_BITS'(x) - meac_pkg::DELTA_BITS'(y);
		bx = $signed({3'b000, box});
		twod = d <<< 1;
		if (box != '0) begin
			if (twod > bx)
				d = d - bx;
			else if (twod < -bx)
				d = d + bx;
		end
		m = d[meac_pkg::DELTA_BITS-1] ? meac_pkg::DELTA_BITS'(-d) : d;
		if (m > meac_pkg::DELTA_BITS'(meac_pkg::DELTA_CLAMP))
			wrap_mag = meac_pkg::DELTA_CLAMP;
		else
			wrap_mag = m[meac_pkg::MAG_BITS-1:0];
	endfunction

	always_ff @(posedge clk) begin
		mag_a_s1 <= wrap_mag(atom.a, lipid.a, cfg.box_a);
		mag_b_s1 <= wrap_mag(atom.b, lipid.b, cfg.box_b);
		same_s1 <= atom.n == lipid.n;
		above_s1 <= atom.n < lipid.n;
		sq_a_s2 <= mag_a_s1 * mag_a_s1;
		sq_b_s2 <= mag_b_s1 * mag_b_s1;
		same_s2 <= same_s1;
		above_s2 <= above_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	logic [meac_pkg::SUM_BITS-1:0] d2;
	assign d2 = meac_pkg::SUM_BITS'(sq_a_s2) + meac_pkg::SUM_BITS'(sq_b_s2);
	assign result.valid = valid_s2;
	assign result.near = d2 <= meac_pkg::SUM_BITS'(cfg.radius_sq);
	assign result.same = same_s2;
	assign result.above = above_s2;
endmodule

/* rtl/membrane_embedded_atom_classifier.sv */
// Top level of the membrane embedded atom classifier.
// Loads and clears produce no result, and loads may follow one another with no gap; a
// configuration write is an APB transfer with no wait states. A query walks the top
// leaflet store, one lipid a cycle through a shared two-stage distance unit fed by a
// registered memory read, and then the bottom store if the top did not enclose the atom;
// the walk of a store stops early once the atom is found enclosed. Each leaflet's walk is
// closed, then the read and distance pipeline is drained, then the leaflet is decided. The
// time a query takes is set by the single read port of each store and the one distance
// unit. The block takes no new request while a query is in work or its result waits at
// the output register.
// Stores are not cleared: only entries below the fill counts are ever read.
module membrane_embedded_atom_classifier (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input meac_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output meac_pkg::out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [5:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_WALK = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;
	meac_pkg::cfg_t cfg_q;
	logic [meac_pkg::FILL_BITS-1:0] top_fill_q, bot_fill_q, idx_q, issued_q;
	logic [meac_pkg::TOTAL_BITS-1:0] top_found_q, bot_found_q;
	logic leaf_q;
	logic enclosed_q, above_q, below_q;
	logic rd_valid_q;
	meac_pkg::proj_t atom_q, wpos, top_rd, bot_rd;
	logic [23:0] id_q;
	meac_pkg::test_t res;
	logic [2:0] reg_idx;
	logic cfg_wr, acc, ld_top, ld_bot;

	assign pready = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			meac_pkg::REG_AXIS_A: prdata[1:0] = cfg_q.axis_a;
			meac_pkg::REG_AXIS_B: prdata[1:0] = cfg_q.axis_b;
			meac_pkg::REG_NORMAL: prdata[1:0] = cfg_q.normal;
			meac_pkg::REG_BOX_A: prdata[22:0] = cfg_q.box_a;
			meac_pkg::REG_BOX_B: prdata[22:0] = cfg_q.box_b;
			meac_pkg::REG_RADIUS: prdata[45:0] = cfg_q.radius_sq;
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{axis_a: 2'd0, axis_b: 2'd1, normal: 2'd2,
				box_a: '0, box_b: '0, radius_sq: '0};
		end else if (cfg_wr) begin
			case (reg_idx)
				meac_pkg::REG_AXIS_A: cfg_q.axis_a <= pwdata[1:0];
				meac_pkg::REG_AXIS_B: cfg_q.axis_b <= pwdata[1:0];
				meac_pkg::REG_NORMAL: cfg_q.normal <= pwdata[1:0];
				meac_pkg::REG_BOX_A: cfg_q.box_a <= pwdata[22:0];
				meac_pkg::REG_BOX_B: cfg_q.box_b <= pwdata[22:0];
				meac_pkg::REG_RADIUS: cfg_q.radius_sq <= pwdata[45:0];
				default: ;
			endcase
		end
	end

	// Selected axes of the incoming item, used for the query atom.
	assign wpos.a = meac_pkg::pick(cfg_q.axis_a, in_data.coord_0, in_data.coord_1,
		in_data.coord_2);
	assign wpos.b = meac_pkg::pick(cfg_q.axis_b, in_data.coord_0, in_data.coord_1,
		in_data.coord_2);
	assign wpos.n = meac_pkg::pick(cfg_q.normal, in_data.coord_0, in_data.coord_1,
		in_data.coord_2);

	assign in_ready = state_q == ST_IDLE;
	assign acc = in_valid && in_ready;
	assign ld_top = acc && in_data.kind == meac_pkg::KIND_TOP
		&& top_fill_q != meac_pkg::FILL_BITS'(meac_pkg::LIPID_DEPTH);
	assign ld_bot = acc && in_data.kind == meac_pkg::KIND_BOTTOM
		&& bot_fill_q != meac_pkg::FILL_BITS'(meac_pkg::LIPID_DEPTH);

	// The stores keep the raw coordinates in load order; the axes are picked on the read
	// side with the current selectors, just as they are for the query atom.
	meac_pkg::proj_t top_raw, bot_raw;
	meac_pkg::proj_t raw_w;
	assign raw_w.a = in_data.coord_0;
	assign raw_w.b = in_data.coord_1;
	assign raw_w.n = in_data.coord_2;

	logic [meac_pkg::ADDR_BITS-1:0] raddr;
	assign raddr = idx_q[meac_pkg::ADDR_BITS-1:0];

	meac_store u_top (.clk(clk), .we(ld_top),
		.waddr(top_fill_q[meac_pkg::ADDR_BITS-1:0]), .wdata(raw_w),
		.raddr(raddr), .rdata(top_raw));
	meac_store u_bot (.clk(clk), .we(ld_bot),
		.waddr(bot_fill_q[meac_pkg::ADDR_BITS-1:0]), .wdata(raw_w),
		.raddr(raddr), .rdata(bot_raw));

	meac_pkg::proj_t sel_raw;
	assign sel_raw = leaf_q ? bot_raw : top_raw;
	assign top_rd.a = meac_pkg::pick(cfg_q.axis_a, sel_raw.a, sel_raw.b, sel_raw.n);
	assign top_rd.b = meac_pkg::pick(cfg_q.axis_b, sel_raw.a, sel_raw.b, sel_raw.n);
	assign top_rd.n = meac_pkg::pick(cfg_q.normal, sel_raw.a, sel_raw.b, sel_raw.n);
	assign bot_rd = top_rd;

	meac_dist u_dist (.clk(clk), .arst_n(arst_n), .in_valid(rd_valid_q),
		.atom(atom_q), .lipid(bot_rd), .cfg(cfg_q), .result(res));

	logic [meac_pkg::FILL_BITS-1:0] cur_fill;
	assign cur_fill = leaf_q ? bot_fill_q : top_fill_q;

	logic hit;
	assign hit = res.valid && res.near && (res.same || (res.above && below_q)
		|| (!res.above && above_q));

	always_ff @(posedge clk) begin
		if (acc) begin
			atom_q <= wpos;
			id_q <= in_data.atom_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_fill_q <= '0;
			bot_fill_q <= '0;
			top_found_q <= '0;
			bot_found_q <= '0;
			idx_q <= '0;
			issued_q <= '0;
			leaf_q <= 1'b0;
			enclosed_q <= 1'b0;
			above_q <= 1'b0;
			below_q <= 1'b0;
			rd_valid_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ld_top)
						top_fill_q <= top_fill_q + 1'b1;
					if (ld_bot)
						bot_fill_q <= bot_fill_q + 1'b1;
					if (acc && in_data.kind == meac_pkg::KIND_CLEAR) begin
						top_fill_q <= '0;
						bot_fill_q <= '0;
						top_found_q <= '0;
						bot_found_q <= '0;
					end
					if (acc && in_data.kind == meac_pkg::KIND_QUERY) begin
						state_q <= ST_WALK;
						leaf_q <= 1'b0;
						idx_q <= '0;
						enclosed_q <= 1'b0;
						above_q <= 1'b0;
						below_q <= 1'b0;
					end
				end
				ST_WALK: begin
					// Issue one read a cycle; each result returns through the registered store read and the two distance stages.
					if (idx_q != cur_fill && !hit) begin
						rd_valid_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end else begin
						rd_valid_q <= 1'b0;
						state_q <= ST_DRAIN;
						issued_q <= meac_pkg::FILL_BITS'(4);
					end
				end
				ST_DRAIN: begin
					if (hit || issued_q == '0)
						state_q <= ST_DONE;
					else
						issued_q <= issued_q - 1'b1;
				end
				ST_DONE: begin
					if (enclosed_q || leaf_q) begin
						out_valid <= 1'b1;
						out_data.atom_out <= id_q;
						if (!enclosed_q) begin
							out_data.leaflet <= meac_pkg::LEAF_NONE;
							out_data.top_total <= top_found_q;
							out_data.bottom_total <= bot_found_q;
						end else if (!leaf_q) begin
							out_data.leaflet <= meac_pkg::LEAF_TOP;
							out_data.top_total <= (top_found_q == meac_pkg::TOTAL_MAX)
								? top_found_q : top_found_q + 1'b1;
							out_data.bottom_total <= bot_found_q;
							if (top_found_q != meac_pkg::TOTAL_MAX)
								top_found_q <= top_found_q + 1'b1;
						end else begin
							out_data.leaflet <= meac_pkg::LEAF_BOTTOM;
							out_data.top_total <= top_found_q;
							out_data.bottom_total <= (bot_found_q == meac_pkg::TOTAL_MAX)
								? bot_found_q : bot_found_q + 1'b1;
							if (bot_found_q != meac_pkg::TOTAL_MAX)
								bot_found_q <= bot_found_q + 1'b1;
						end
						state_q <= ST_OUT;
					end else begin
						leaf_q <= 1'b1;
						idx_q <= '0;
						above_q <= 1'b0;
						below_q <= 1'b0;
						state_q <= ST_WALK;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// Fold in each returning near lipid verdict while the walk is live and the atom is not yet enclosed.
			if ((state_q == ST_WALK || state_q == ST_DRAIN) && res.valid && res.near
				&& !enclosed_q) begin
				if (hit)
					enclosed_q <= 1'b1;
				if (res.above)
					above_q <= 1'b1;
				else
					below_q <= 1'b1;
			end
		end
	end
endmodule

/* rtl/meac_checker.sv */
// Port-level checker for the membrane atom classifier, bound to the top level.
module meac_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input meac_pkg::out_item_t out_data,
	input logic pready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while result pending");
	a_leaflet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.leaflet != 2'd3)
		else $error("bad leaflet code");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request withdrawn before it was taken");
endmodule

bind membrane_embedded_atom_classifier meac_checker u_meac_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data), .pready(pready));

/* tb/membrane_embedded_atom_classifier_test.sv */
// Testbench for the membrane atom classifier: directed table, random traffic and a scoreboard.
`timescale 1ns / 100ps

module membrane_embedded_atom_classifier_test;
	// The deepest store we ever fill in random traffic; small stores keep queries short.
	localparam int RAND_LIPIDS = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	meac_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	meac_pkg::out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [5:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	always #5 clk = ~clk;

	membrane_embedded_atom_classifier DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Predictor state: our own copy of the stores, counters and registers.
	logic signed [meac_pkg::COORD_BITS-1:0] top_pos [meac_pkg::LIPID_DEPTH][3];
	logic signed [meac_pkg::COORD_BITS-1:0] bot_pos [meac_pkg::LIPID_DEPTH][3];
	int unsigned top_count, bot_count;
	logic [meac_pkg::TOTAL_BITS-1:0] top_hits, bot_hits;
	logic [1:0] sel_a, sel_b, sel_n;
	logic [meac_pkg::BOX_BITS-1:0] wrap_a, wrap_b;
	logic [meac_pkg::RAD_BITS-1:0] reach_sq;

	meac_pkg::out_item_t pending_verdicts [$];
	int mismatches = 0;

	function automatic int unsigned axis_index(input logic [1:0] s);
		return (s == 2'd3) ? 0 : int'(s);
	endfunction

	// Squared minimum-image distance along one in-plane axis, with the magnitude clamp.
	function automatic longint unsigned axis_dist_sq(input longint d, input longint box);
		if (box != 0) begin
			if (2 * d > box)
				d -= box;
			else if (2 * d < -box)
				d += box;
		end
		if (d < 0)
			d = -d;
		if (d > 64'sd16777216)
			d = 64'sd16777216;
		return longint'(d) * longint'(d);
	endfunction

	// Walk one leaflet store in load order and decide whether it encloses the atom.
	function automatic bit leaflet_encloses(input bit use_top, input longint ac[3]);
		int unsigned ia, ib, in_, fill;
		bit above, below;
		longint lc[3];
		longint unsigned d2;
		ia = axis_index(sel_a);
		ib = axis_index(sel_b);
		in_ = axis_index(sel_n);
		fill = use_top ? top_count : bot_count;
		above = 1'b0;
		below = 1'b0;
		for (int j = 0; j < fill; j++) begin
			for (int k = 0; k < 3; k++)
				lc[k] = use_top ? longint'(top_pos[j][k]) : longint'(bot_pos[j][k]);
			d2 = axis_dist_sq(ac[ia] - lc[ia], longint'(wrap_a))
				+ axis_dist_sq(ac[ib] - lc[ib], longint'(wrap_b));
			if (d2 > longint'(reach_sq))
				continue;
			if (ac[in_] == lc[in_])
				return 1'b1;
			if (ac[in_] < lc[in_])
				above = 1'b1;
			else
				below = 1'b1;
			if (above && below)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Apply one accepted request to the predictor and queue any verdict it causes.
	task automatic classify_request(input meac_pkg::in_item_t r);
		longint ac[3];
		meac_pkg::out_item_t v;
		ac[0] = longint'(r.coord_0);
		ac[1] = longint'(r.coord_1);
		ac[2] = longint'(r.coord_2);
		case (r.kind)
			meac_pkg::KIND_TOP: begin
				if (top_count < meac_pkg::LIPID_DEPTH) begin
					top_pos[top_count] = '{r.coord_0, r.coord_1, r.coord_2};
					top_count++;
				end
			end
			meac_pkg::KIND_BOTTOM: begin
				if (bot_count < meac_pkg::LIPID_DEPTH) begin
					bot_pos[bot_count] = '{r.coord_0, r.coord_1, r.coord_2};
					bot_count++;
				end
			end
			meac_pkg::KIND_CLEAR: begin
				top_count = 0;
				bot_count = 0;
				top_hits = '0;
				bot_hits = '0;
			end
			default: begin
				v.atom_out = r.atom_id;
				v.leaflet = meac_pkg::LEAF_NONE;
				if (leaflet_encloses(1'b1, ac)) begin
					v.leaflet = meac_pkg::LEAF_TOP;
					if (top_hits != meac_pkg::TOTAL_MAX)
						top_hits++;
				end else if (leaflet_encloses(1'b0, ac)) begin
					v.leaflet = meac_pkg::LEAF_BOTTOM;
					if (bot_hits != meac_pkg::TOTAL_MAX)
						bot_hits++;
				end
				v.top_total = top_hits;
				v.bottom_total = bot_hits;
				pending_verdicts.push_back(v);
			end
		endcase
	endtask

	// Register write over the configuration port, mirrored into the predictor.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			meac_pkg::REG_AXIS_A: sel_a = val[1:0];
			meac_pkg::REG_AXIS_B: sel_b = val[1:0];
			meac_pkg::REG_NORMAL: sel_n = val[1:0];
			meac_pkg::REG_BOX_A: wrap_a = val[meac_pkg::BOX_BITS-1:0];
			meac_pkg::REG_BOX_B: wrap_b = val[meac_pkg::BOX_BITS-1:0];
			meac_pkg::REG_RADIUS: reach_sq = val[meac_pkg::RAD_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [1:0] a, input logic [1:0] b, input logic [1:0] n,
			input logic [meac_pkg::BOX_BITS-1:0] ba, input logic [meac_pkg::BOX_BITS-1:0] bb,
			input logic [meac_pkg::RAD_BITS-1:0] r);
		write_reg(meac_pkg::REG_AXIS_A, 64'(a));
		write_reg(meac_pkg::REG_AXIS_B, 64'(b));
		write_reg(meac_pkg::REG_NORMAL, 64'(n));
		write_reg(meac_pkg::REG_BOX_A, 64'(ba));
		write_reg(meac_pkg::REG_BOX_B, 64'(bb));
		write_reg(meac_pkg::REG_RADIUS, 64'(r));
	endtask

	// Present one request after a random gap and hold it until the block takes it.
	// With no gap the valid stays high straight from the previous request.
	task automatic send_request(input meac_pkg::in_item_t r);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
		classify_request(r);
	endtask

	// Idle phase boundary: drop the request line, wait for all verdicts, then let the
	// block settle.
	task automatic settle;
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (2100) @(posedge clk);
	endtask

	function automatic meac_pkg::in_item_t make_item(input logic [1:0] k, input int c0,
			input int c1, input int c2, input logic [23:0] id);
		meac_pkg::in_item_t r;
		r.kind = k;
		r.coord_0 = c0[meac_pkg::COORD_BITS-1:0];
		r.coord_1 = c1[meac_pkg::COORD_BITS-1:0];
		r.coord_2 = c2[meac_pkg::COORD_BITS-1:0];
		r.atom_id = id;
		return r;
	endfunction

	// Random coordinate near a small cluster so that radii actually catch lipids, or over the full range when wide is set.
	function automatic int near_coord(input bit wide);
		if (wide)
			return int'($urandom) >>> 8;
		return $urandom_range(0, 4000) - 2000;
	endfunction

	function automatic meac_pkg::in_item_t random_request(input bit wide);
		int roll;
		logic [1:0] k;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			k = meac_pkg::KIND_TOP;
		else if (roll < 60)
			k = meac_pkg::KIND_BOTTOM;
		else if (roll < 98)
			k = meac_pkg::KIND_QUERY;
		else
			k = meac_pkg::KIND_CLEAR;
		return make_item(k, near_coord(wide), near_coord(wide), near_coord(wide),
			24'($urandom));
	endfunction

	// Directed rows; the expected verdict is typed in where it is obvious, else predicted.
	typedef struct {
		meac_pkg::in_item_t req;
		bit known;
		logic [1:0] leaf;
	} row_t;

	row_t plan [$];

	task automatic add_row(input meac_pkg::in_item_t r, input bit known,
			input logic [1:0] leaf);
		row_t w;
		w.req = r;
		w.known = known;
		w.leaf = leaf;
		plan.push_back(w);
	endtask

	// Result side: random stall, then compare with the oldest expectation.
	initial begin : verdict_checker
		meac_pkg::out_item_t want;
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			wait_cycles = $urandom_range(0, 2) == 0 ? $urandom_range(0, 12) : 0;
			if (wait_cycles != 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected verdict %p", out_data);
			end else begin
				want = pending_verdicts.pop_front();
				if (out_data.atom_out !== want.atom_out || out_data.leaflet !== want.leaflet
						|| out_data.top_total !== want.top_total
						|| out_data.bottom_total !== want.bottom_total) begin
					mismatches++;
					if (mismatches <= 10)
						$display("verdict mismatch: expected %p, got %p", want, out_data);
				end
			end
		end
	end

	initial begin : stimulus
		int mx, mn;
		mx = 8388607;
		mn = -8388608;
		top_count = 0;
		bot_count = 0;
		top_hits = '0;
		bot_hits = '0;
		sel_a = 2'd0;
		sel_b = 2'd1;
		sel_n = 2'd2;
		wrap_a = '0;
		wrap_b = '0;
		reach_sq = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stores after reset: the atom is never enclosed.
		add_row(make_item(meac_pkg::KIND_QUERY, 0, 0, 0, 24'hFFFFFF), 1'b1,
			meac_pkg::LEAF_NONE);
		// A lipid at exactly the atom's height encloses it even with a zero radius.
		add_row(make_item(meac_pkg::KIND_TOP, mx, mn, 5, 24'h0), 1'b0, meac_pkg::LEAF_NONE);
		add_row(make_item(meac_pkg::KIND_QUERY, mx, mn, 5, 24'h000001), 1'b1,
			meac_pkg::LEAF_TOP);
		// One lipid above only: not enclosed.
		add_row(make_item(meac_pkg::KIND_BOTTOM, 0, 0, mx, 24'h0), 1'b0, meac_pkg::LEAF_NONE);
		add_row(make_item(meac_pkg::KIND_QUERY, 0, 0, 0, 24'h000002), 1'b1,
			meac_pkg::LEAF_NONE);
		// Above and below in the bottom leaflet.
		add_row(make_item(meac_pkg::KIND_BOTTOM, 0, 0, mn, 24'h0), 1'b0, meac_pkg::LEAF_NONE);
		add_row(make_item(meac_pkg::KIND_QUERY, 0, 0, 0, 24'h000003), 1'b1,
			meac_pkg::LEAF_BOTTOM);
		// Extreme in-plane distances fall outside the zero radius.
		add_row(make_item(meac_pkg::KIND_QUERY, mn, mx, 0, 24'hABCDEF), 1'b0,
			meac_pkg::LEAF_NONE);
		add_row(make_item(meac_pkg::KIND_CLEAR, mx, mx, mx, 24'hFFFFFF), 1'b0,
			meac_pkg::LEAF_NONE);
		add_row(make_item(meac_pkg::KIND_QUERY, mx, mn, 5, 24'h800000), 1'b1,
			meac_pkg::LEAF_NONE);
		foreach (plan[i]) begin
			send_request(plan[i].req);
			if (plan[i].known && plan[i].req.kind == meac_pkg::KIND_QUERY
					&& pending_verdicts[$].leaflet !== plan[i].leaf) begin
				mismatches++;
				if (mismatches <= 10)
					$display("directed row %0d: predictor gives %0d, table says %0d",
						i, pending_verdicts[$].leaflet, plan[i].leaf);
			end
		end
		settle();

		// Wrapping on both axes with odd selectors, including the unused value three.
		write_all(2'd3, 2'd2, 2'd1, 23'h7FFFFF, 23'd3000, 46'h3FFF_FFFF_FFFF);
		send_request(make_item(meac_pkg::KIND_CLEAR, 0, 0, 0, 0));
		for (int i = 0; i < 6; i++)
			send_request(make_item(i % 2 ? meac_pkg::KIND_BOTTOM : meac_pkg::KIND_TOP,
				mn, mx, near_coord(0), 0));
		for (int i = 0; i < 6; i++)
			send_request(random_request(1'b1));
		settle();

		// Random phases over several settings, stores kept small.
		for (int ph = 0; ph < 5; ph++) begin
			write_all(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)),
				ph == 1 ? 23'd0 : 23'($urandom_range(1000, 5000)),
				ph == 4 ? 23'h7FFFFF : 23'($urandom_range(0, 5000)),
				ph == 3 ? 46'd0 : 46'($urandom_range(100000, 4000000)));
			send_request(make_item(meac_pkg::KIND_CLEAR, 0, 0, 0, 0));
			for (int i = 0; i < 52; i++) begin
				meac_pkg::in_item_t r;
				r = random_request(ph == 2);
				if (r.kind == meac_pkg::KIND_TOP && top_count >= RAND_LIPIDS)
					r.kind = meac_pkg::KIND_QUERY;
				if (r.kind == meac_pkg::KIND_BOTTOM && bot_count >= RAND_LIPIDS)
					r.kind = meac_pkg::KIND_QUERY;
				send_request(r);
			end
			settle();
		end

		if (mismatches == 0)
			$display("membrane_embedded_atom_classifier_test: clean");
		else
			$display("membrane_embedded_atom_classifier_test: errors");
		$finish;
	end

	initial begin : watchdog
		#20ms;
		$display("membrane_embedded_atom_classifier_test: errors");
		$finish;
	end
endmodule
